/* hdl/tba_pkg.sv */
`default_nettype none

package tba_pkg;

  // Full marks of the two children of one tree node, kept together in one memory entry.
  typedef struct packed {
    logic right;
    logic left;
  } pair_t;

  typedef logic [1:0] status_t;

  localparam status_t ST_OK    = 2'd0;
  localparam status_t ST_FULL  = 2'd1;
  localparam status_t ST_RANGE = 2'd2;

  localparam logic OP_ALLOC   = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  localparam int ID_W   = 17;
  localparam int BASE_W = 16;

  // Configuration register indexes.
  localparam logic REG_ID_BASE = 1'b0;

  localparam logic [BASE_W-1:0] ID_BASE_RESET = 16'd300;

endpackage

`default_nettype wire

/* hdl/tba_mark_mem.sv */
`default_nettype none

module tba_mark_mem #(
  parameter int ADDR_W = 13
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  rd_en,
  input  wire [ADDR_W-1:0]     rd_addr,
  output tba_pkg::pair_t       rd_data,
  input  wire                  wr_en,
  input  wire [ADDR_W-1:0]     wr_addr,
  input  tba_pkg::pair_t       wr_data,
  output logic                 ready
);
  import tba_pkg::*;

  localparam int DEPTH = 1 << ADDR_W;

  pair_t             mem [DEPTH];
  pair_t             rd_data_r;
  logic              clr_busy_r;
  logic [ADDR_W-1:0] clr_addr_r;

  // After reset every entry is swept to zero, one per cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (clr_busy_r) begin
      clr_addr_r <= clr_addr_r + 1'b1;
      if (clr_addr_r == ADDR_W'(DEPTH - 1)) begin
        clr_busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clr_busy_r) begin
      mem[clr_addr_r] <= '0;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;
  assign ready   = !clr_busy_r;

endmodule

`default_nettype wire

/* hdl/tree_bitmap_id_allocator.sv */
`default_nettype none
// Allocate: one memory read per level on the way down and one write per level on the way up.
// Release: one write per level along the path; a full pool or an out-of-pool release skips the tree walk.
// One request is in flight at a time; the next word is taken while a result waits.
// Reset clears control state at once; the tree memory is then swept, one entry a
// cycle, over all 2^ceil(log2(LEAVES)) entries before words are taken.

module tree_bitmap_id_allocator #(
  parameter int LEAVES = 8192
) (
  input  wire                        clk,
  input  wire                        rst_n,
  input  wire                        in_valid,
  output logic                       in_stall,
  input  wire                        in_operation,
  input  wire [tba_pkg::ID_W-1:0]    in_release_id,
  output logic                       out_valid,
  input  wire                        out_stall,
  output logic [tba_pkg::ID_W-1:0]   out_granted_id,
  output logic [1:0]                 out_status,
  input  wire                        psel,
  input  wire                        penable,
  input  wire                        pwrite,
  input  wire [2:0]                  paddr,
  input  wire [31:0]                 pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);
  import tba_pkg::*;

  // Tree depth: the leaf level holds 2^L slots, the smallest power of two covering LEAVES.
  // Each internal node n (1 .. 2^L-1) owns one memory entry with the marks of its children.
  localparam int L     = $clog2(LEAVES);
  localparam int LVW   = (L > 1) ? $clog2(L) : 1;
  localparam logic [LVW-1:0]  LAST_LV  = LVW'(L - 1);
  localparam logic [ID_W-1:0] LEAVES_V = ID_W'(LEAVES);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DOWN,
    S_UP,
    S_REL,
    S_FIN
  } state_t;

  state_t            state_r;
  logic [BASE_W-1:0] base_r;
  logic              root_full_r;
  logic [L:0]        node_r;
  logic [L-1:0]      rem_r;
  logic [LVW-1:0]    level_r;
  logic [L-1:0]      sib_r;
  logic              full_r;
  logic [ID_W-1:0]   res_id_r;
  status_t           res_status_r;
  logic              out_valid_r;
  logic [ID_W-1:0]   out_granted_id_r;
  status_t           out_status_r;

  logic              mem_ready;
  logic              rd_en;
  logic [L-1:0]      rd_addr;
  pair_t             rd_data;
  logic              wr_en;
  logic [L-1:0]      wr_addr;
  pair_t             wr_data;

  logic              in_take;
  logic              out_take;
  logic              fin_load;
  logic              cfg_wr;
  logic [ID_W:0]     rel_diff;
  logic              rel_outside;
  logic              dir;
  logic [L:0]        child_node;
  logic              both_full;
  logic              sib_bit;
  logic              last_lv;
  logic              pad_leaf;
  logic              up_dir;

  tba_mark_mem #(
    .ADDR_W (L)
  ) u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .ready   (mem_ready)
  );

  // Handshakes. A word is only taken once the tree memory has been swept.
  assign in_stall  = !((state_r == S_IDLE) && mem_ready);
  assign in_take   = in_valid && !in_stall;
  assign out_take  = out_valid_r && !out_stall;
  assign out_valid = out_valid_r;
  assign out_granted_id = out_granted_id_r;
  assign out_status     = out_status_r;

  // The finished result moves into the output register once that register is free
  // or is being emptied in the same cycle.
  assign fin_load = (state_r == S_FIN) && (!out_valid_r || !out_stall);

  // Configuration port: single register at byte address 0.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_ID_BASE);
  assign prdata = (paddr[2] == REG_ID_BASE) ? {16'd0, base_r} : 32'd0;

  // Release range check: negative or past the pool end means the id is not ours.
  assign rel_diff    = {1'b0, in_release_id} - {2'b00, base_r};
  assign rel_outside = rel_diff[ID_W] || (rel_diff[ID_W-1:0] >= LEAVES_V);

  // On the way down the next child comes from the read marks (allocate) or the
  // id bits (release). Left is preferred whenever it is not full.
  assign both_full  = rd_data.left && rd_data.right;
  assign dir        = (state_r == S_REL) ? rem_r[L-1] : rd_data.left;
  assign sib_bit    = dir ? rd_data.left : rd_data.right;
  assign child_node = {node_r[L-1:0], dir};
  assign last_lv    = (level_r == LAST_LV);
  assign pad_leaf   = (ID_W'(child_node[L-1:0]) >= LEAVES_V);
  assign up_dir     = node_r[0];

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = child_node[L-1:0];
    wr_en   = 1'b0;
    wr_addr = node_r[L-1:0];
    wr_data = rd_data;
    unique case (state_r)
      S_IDLE: begin
        // Every walk begins at the root entry.
        rd_addr = L'(1);
        rd_en   = in_take && ((in_operation == OP_ALLOC) ? !root_full_r : !rel_outside);
      end
      S_DOWN: begin
        rd_en = !both_full && !last_lv;
      end
      S_UP: begin
        // Parent of the current node takes the new mark of this child; the
        // sibling's mark was captured on the way down.
        wr_en   = 1'b1;
        wr_addr = node_r[L:1];
        if (up_dir) begin
          wr_data.left  = sib_r[level_r];
          wr_data.right = full_r;
        end else begin
          wr_data.left  = full_r;
          wr_data.right = sib_r[level_r];
        end
      end
      S_REL: begin
        // Clear this node's mark of the child on the path and read the next
        // level, which is always a different entry.
        wr_en = 1'b1;
        rd_en = !last_lv;
        if (dir) begin
          wr_data.right = 1'b0;
        end else begin
          wr_data.left = 1'b0;
        end
      end
      S_FIN: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      base_r      <= ID_BASE_RESET;
      root_full_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr) begin
        base_r <= pwdata[BASE_W-1:0];
      end
      if (fin_load) begin
        out_valid_r <= 1'b1;
      end else if (out_take) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_take) begin
            node_r   <= (L + 1)'(1);
            level_r  <= '0;
            rem_r    <= rel_diff[L-1:0];
            res_id_r <= '0;
            if (in_operation == OP_ALLOC) begin
              if (root_full_r) begin
                res_status_r <= ST_FULL;
                state_r      <= S_FIN;
              end else begin
                state_r <= S_DOWN;
              end
            end else if (rel_outside) begin
              res_status_r <= ST_RANGE;
              state_r      <= S_FIN;
            end else begin
              root_full_r <= 1'b0;
              state_r     <= S_REL;
            end
          end
        end
        S_DOWN: begin
          sib_r[level_r] <= sib_bit;
          node_r         <= child_node;
          if (both_full) begin
            res_status_r <= ST_FULL;
            state_r      <= S_FIN;
          end else if (last_lv) begin
            // A padding leaf is only reached once every real id is taken.
            if (pad_leaf) begin
              res_status_r <= ST_FULL;
              state_r      <= S_FIN;
            end else begin
              full_r   <= 1'b1;
              res_id_r <= {1'b0, base_r} + ID_W'(child_node[L-1:0]);
              state_r  <= S_UP;
            end
          end else begin
            level_r <= level_r + 1'b1;
          end
        end
        S_UP: begin
          node_r  <= node_r >> 1;
          full_r  <= full_r && sib_r[level_r];
          level_r <= level_r - 1'b1;
          if (level_r == '0) begin
            root_full_r  <= full_r && sib_r[level_r];
            res_status_r <= ST_OK;
            state_r      <= S_FIN;
          end
        end
        S_REL: begin
          node_r  <= child_node;
          rem_r   <= rem_r << 1;
          level_r <= level_r + 1'b1;
          if (last_lv) begin
            res_status_r <= ST_OK;
            state_r      <= S_FIN;
          end
        end
        S_FIN: begin
          if (fin_load) begin
            out_granted_id_r <= res_id_r;
            out_status_r     <= res_status_r;
            state_r          <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // Reads and writes of the tree memory in one cycle never hit the same entry.
  assert property (@(posedge clk) disable iff (!rst_n)
    (rd_en && wr_en) |-> (rd_addr != wr_addr))
    else $error("tree memory read and write collide");

  // The root only becomes full at the top of an allocate's upward pass.
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(root_full_r) |-> $past(state_r == S_UP))
    else $error("root marked full outside an allocate");

  // A failed request never carries an id; releases carry none either, but only failures are checked here.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_status_r != ST_OK)) |-> (out_granted_id_r == '0))
    else $error("id returned with a failure status");

  // No word is taken while the memory is still being swept.
  assert property (@(posedge clk) disable iff (!rst_n)
    !mem_ready |-> in_stall)
    else $error("word taken during memory sweep");

endmodule

`default_nettype wire

/* dv/tb_tree_bitmap_id_allocator.sv */
`timescale 1ns / 100ps

import tba_pkg::*;

// Shadow of the allocator's tree of full marks. Every word taken by the block is
// played through this copy at once, and the grant it must produce is queued in
// order; the block answers strictly in order, one grant per word.
class id_pool_tracker #(int LEAVES = 8192, int SPAN = 8192);

  typedef struct packed {
    logic [ID_W-1:0] id;
    status_t         status;
  } grant_t;

  bit                full_mark [1:2*SPAN-1];
  logic [BASE_W-1:0] id_base = ID_BASE_RESET;
  grant_t            due[$];
  int                held[$];
  int                mismatches = 0;

  function void flag(string what);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%0t: MISMATCH %s", $time, what);
    end
  endfunction

  function int outstanding();
    return due.size();
  endfunction

  function void note_request(logic op, logic [ID_W-1:0] rid);
    grant_t g;
    int     node;
    int     off;
    int     r;
    int     b;
    int     i;
    g.id     = '0;
    g.status = ST_OK;
    r        = rid;
    b        = id_base;
    if (op == OP_ALLOC) begin
      if (full_mark[1]) begin
        g.status = ST_FULL;
      end else begin
        // Leftmost descent: the left child wins whenever it still has room.
        node = 1;
        while (node < SPAN && g.status == ST_OK) begin
          if (!full_mark[2*node]) begin
            node = 2 * node;
          end else if (!full_mark[2*node+1]) begin
            node = 2 * node + 1;
          end else begin
            g.status = ST_FULL;
          end
        end
        // A free padding leaf means every real id is already taken.
        if (g.status == ST_OK && node - SPAN >= LEAVES) begin
          g.status = ST_FULL;
        end
        if (g.status == ST_OK) begin
          off             = node - SPAN;
          full_mark[node] = 1'b1;
          while (node > 1) begin
            node = node / 2;
            if (full_mark[2*node] && full_mark[2*node+1]) begin
              full_mark[node] = 1'b1;
            end
          end
          g.id = ID_W'(b + off);
          held.push_back(off);
        end
      end
    end else begin
      if (r < b || r - b >= LEAVES) begin
        g.status = ST_RANGE;
      end else begin
        off  = r - b;
        node = SPAN + off;
        while (node != 0) begin
          full_mark[node] = 1'b0;
          node            = node / 2;
        end
        for (i = 0; i < held.size(); i++) begin
          if (held[i] == off) begin
            held.delete(i);
            break;
          end
        end
      end
    end
    due.push_back(g);
  endfunction

  function void check_grant(logic [ID_W-1:0] id, logic [1:0] status);
    grant_t g;
    if (due.size() == 0) begin
      flag($sformatf("grant with none pending: id=%0d status=%0d", id, status));
      return;
    end
    g = due.pop_front();
    if (id !== g.id) begin
      flag($sformatf("granted_id expected %0d, got %0d", g.id, id));
    end
    if (status !== g.status) begin
      flag($sformatf("status expected %0d, got %0d", g.status, status));
    end
  endfunction

endclass

module tb_tree_bitmap_id_allocator;

  localparam int CLK_PERIOD     = 10;
  localparam int POOL_LEAVES    = 8192;
  localparam int POOL_SPAN      = 1 << $clog2(POOL_LEAVES);
  // After reset the block sweeps all POOL_SPAN entries of its tree memory before it
  // takes a word, so the quiet-time limit is set well clear of that sweep.
  localparam int QUIET_LIMIT    = 5 * POOL_SPAN;
  // This drain time comfortably covers one allocate word.
  localparam int DRAIN_CYCLES   = 2 * $clog2(POOL_SPAN) + 8;
  localparam logic [2:0] BASE_ADDR = 3'(4 * REG_ID_BASE);

  logic            clk = 1'b0;
  logic            rst_n;
  logic            in_valid;
  logic            in_stall;
  logic            in_operation;
  logic [ID_W-1:0] in_release_id;
  logic            out_valid;
  logic            out_stall = 1'b0;
  logic [ID_W-1:0] out_granted_id;
  logic [1:0]      out_status;
  logic            psel;
  logic            penable;
  logic            pwrite;
  logic [2:0]      paddr;
  logic [31:0]     pwdata;
  logic [31:0]     prdata;
  logic            pready;

  // Percentages of cycles in which the sender holds back a word and the
  // receiver stalls; the main sequence changes them from phase to phase.
  int in_gap_pct    = 0;
  int out_stall_pct = 0;
  int quiet         = 0;

  id_pool_tracker #(POOL_LEAVES, POOL_SPAN) pool = new;

  tree_bitmap_id_allocator #(
    .LEAVES(POOL_LEAVES)
  ) dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_operation  (in_operation),
    .in_release_id (in_release_id),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_granted_id(out_granted_id),
    .out_status    (out_status),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // The receiver decides afresh on every falling edge whether to stall.
  always @(negedge clk) begin
    out_stall <= (out_stall_pct != 0) && ($urandom_range(0, 99) < out_stall_pct);
  end

  // Grants are taken at the rising edge; the values seen here are those from
  // before the edge, as the block only updates them through its own registers.
  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
      pool.check_grant(out_granted_id, out_status);
    end
  end

  // Watchdog: counts cycles in which no word moves on either channel.
  initial begin : watchdog
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet = 0;
      end else begin
        quiet = quiet + 1;
      end
    end
    $display("%0t: no word moved for %0d cycles", $time, QUIET_LIMIT);
    $display("Test completed with failures");
    $finish;
  end

  // Offers one request word, after random idle cycles in some phases, and
  // returns at the rising edge at which the block takes it.
  task automatic send_word(logic op, logic [ID_W-1:0] rid);
    @(negedge clk);
    // The sender idles cycle by cycle, deciding afresh on each falling edge.
    while (in_gap_pct != 0 && $urandom_range(0, 99) < in_gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_operation  <= op;
    in_release_id <= rid;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pool.note_request(op, rid);
  endtask

  task automatic stop_input();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  // Rewrites id_base once the block is idle, then reads it back.
  task automatic program_base(logic [BASE_W-1:0] value);
    while (pool.outstanding() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= BASE_ADDR;
    pwdata  <= 32'(value);
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    pool.id_base = value;
    @(negedge clk);
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata[BASE_W-1:0] !== value) begin
      pool.flag($sformatf("id_base read back %0d, written %0d",
                          prdata[BASE_W-1:0], value));
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Random traffic: mostly allocates and releases of ids really held, so the tree
  // fills and drains in earnest, with some releases of random in-pool ids and some noise.
  task automatic run_random(int count, int alloc_pct);
    int pick;
    int rid;
    repeat (count) begin
      pick = $urandom_range(0, 99);
      if (pick < alloc_pct) begin
        send_word(OP_ALLOC, ID_W'($urandom_range(0, (1 << ID_W) - 1)));
      end else if (pick < 90 && pool.held.size() != 0) begin
        rid = pool.id_base + pool.held[$urandom_range(0, pool.held.size() - 1)];
        send_word(OP_RELEASE, ID_W'(rid));
      end else if (pick < 94) begin
        rid = pool.id_base + $urandom_range(0, POOL_LEAVES - 1);
        send_word(OP_RELEASE, ID_W'(rid));
      end else begin
        send_word(OP_RELEASE, ID_W'($urandom_range(0, (1 << ID_W) - 1)));
      end
    end
  endtask

  initial begin
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_operation  = OP_ALLOC;
    in_release_id = '0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part at the reset base: leftmost allocation, refilling a hole,
    // releasing a free id, and both sides of the pool's edges.
    send_word(OP_ALLOC, '0);
    send_word(OP_ALLOC, '1);
    send_word(OP_ALLOC, '0);
    send_word(OP_RELEASE, ID_W'(301));
    send_word(OP_ALLOC, '0);
    send_word(OP_RELEASE, ID_W'(305));
    send_word(OP_RELEASE, ID_W'(299));
    send_word(OP_RELEASE, ID_W'(300 + POOL_LEAVES));
    send_word(OP_RELEASE, ID_W'(300 + POOL_LEAVES - 1));
    send_word(OP_RELEASE, '0);
    send_word(OP_RELEASE, '1);
    send_word(OP_RELEASE, ID_W'(300));
    stop_input();

    // Lowest base: an id of zero is inside the pool.
    program_base('0);
    send_word(OP_RELEASE, '0);
    send_word(OP_ALLOC, '0);
    send_word(OP_RELEASE, ID_W'(POOL_LEAVES));
    send_word(OP_RELEASE, ID_W'(POOL_LEAVES - 1));
    stop_input();

    // Highest base: granted ids run past sixteen bits.
    program_base('1);
    send_word(OP_ALLOC, '1);
    send_word(OP_RELEASE, ID_W'(65534));
    send_word(OP_RELEASE, ID_W'(65535 + POOL_LEAVES - 1));
    send_word(OP_RELEASE, ID_W'(65535 + POOL_LEAVES));
    send_word(OP_RELEASE, '1);
    stop_input();

    // Sender idles lightly, receiver heavily.
    program_base(BASE_W'($urandom_range(0, 65535)));
    in_gap_pct    = 14;
    out_stall_pct = 50;
    run_random(240, 55);
    stop_input();

    // And the other way round.
    program_base(BASE_W'($urandom_range(0, 65535)));
    in_gap_pct    = 50;
    out_stall_pct = 14;
    run_random(240, 45);
    stop_input();

    // No idling: churn with ids near the top of the range.
    program_base('1);
    in_gap_pct    = 0;
    out_stall_pct = 0;
    run_random(220, 50);
    stop_input();

    while (pool.outstanding() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (pool.mismatches == 0 && pool.outstanding() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

/* sim.f */
hdl/tba_pkg.sv
hdl/tba_mark_mem.sv
hdl/tree_bitmap_id_allocator.sv
dv/tb_tree_bitmap_id_allocator.sv
